[hdl/ubd_pkg.sv]
// Shared types, constants and helpers for the UTF-8 byte decoder.
// Used by ubd_front, ubd_queue, ubd_exec and utf8_byte_decoder; no dependencies.
`default_nettype none

package ubd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int BYTE_W      = 8;
    localparam int CP_W        = 31;
    localparam int CNT_W       = 3;

    // Byte range boundaries
    localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MIN = 8'hFC;
    localparam logic [BYTE_W-1:0] BAD_MIN   = 8'hFE;

    // Values rejected at the end of a sequence
    localparam logic [CP_W-1:0] SURR_LO    = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI    = 31'h0000_DFFF;
    localparam logic [CP_W-1:0] NONCHAR_LO = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] NONCHAR_HI = 31'h0000_FFFF;

    typedef enum logic [1:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD,
        KIND_BAD
    } kind_t;

    // One classified byte handed from the front to the back
    typedef struct packed {
        logic                  mode;
        kind_t                 kind;
        logic [BYTE_W-1:0]     data;
        logic [CNT_W-1:0]      extra;
        logic                  nov;
        logic [CP_W-1:0]       lead_val;
    } item_t;

    // Result flags, lowest bit first in tuser
    typedef struct packed {
        logic resend;
        logic need_more;
        logic complete;
    } flags_t;

    // Lowest first-continuation payload that proves a long form is not overlong
    function automatic logic [5:0] first_cont_limit(input logic [CNT_W-1:0] extra);
        logic [5:0] lim;
        lim = 6'h00;
        unique case (extra)
            3'd2:    lim = 6'h20;
            3'd3:    lim = 6'h10;
            3'd4:    lim = 6'h08;
            3'd5:    lim = 6'h04;
            default: lim = 6'h00;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

[hdl/ubd_front.sv]
// Front end: mode register and byte classification.
// Depends on ubd_pkg.
`default_nettype none

module ubd_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic                        cfg_data,
    input  wire logic [ubd_pkg::BYTE_W-1:0]  byte_in,
    output      ubd_pkg::item_t              item
);

    logic mode_reg;
    logic mode_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Classify the byte and prebuild the lead payload at its final position
    always_comb
    begin
        item          = '0;
        item.mode     = mode_reg;
        item.data     = byte_in;
        item.kind     = ubd_pkg::KIND_BAD;
        priority if (byte_in < ubd_pkg::CONT_MIN)
        begin
            item.kind = ubd_pkg::KIND_ASCII;
        end
        else if (byte_in < ubd_pkg::LEAD2_MIN)
        begin
            item.kind = ubd_pkg::KIND_CONT;
        end
        else if (byte_in < ubd_pkg::LEAD3_MIN)
        begin
            item.kind     = ubd_pkg::KIND_LEAD;
            item.extra    = 3'd1;
            item.lead_val = {20'b0, byte_in[4:0], 6'b0};
            item.nov      = |byte_in[4:1];
        end
        else if (byte_in < ubd_pkg::LEAD4_MIN)
        begin
            item.kind     = ubd_pkg::KIND_LEAD;
            item.extra    = 3'd2;
            item.lead_val = {15'b0, byte_in[3:0], 12'b0};
            item.nov      = |byte_in[3:0];
        end
        else if (byte_in < ubd_pkg::LEAD5_MIN)
        begin
            item.kind     = ubd_pkg::KIND_LEAD;
            item.extra    = 3'd3;
            item.lead_val = {10'b0, byte_in[2:0], 18'b0};
            item.nov      = |byte_in[2:0];
        end
        else if (byte_in < ubd_pkg::LEAD6_MIN)
        begin
            item.kind     = ubd_pkg::KIND_LEAD;
            item.extra    = 3'd4;
            item.lead_val = {5'b0, byte_in[1:0], 24'b0};
            item.nov      = |byte_in[1:0];
        end
        else if (byte_in < ubd_pkg::BAD_MIN)
        begin
            item.kind     = ubd_pkg::KIND_LEAD;
            item.extra    = 3'd5;
            item.lead_val = {byte_in[0], 30'b0};
            item.nov      = byte_in[0];
        end
        else
        begin
            item.kind = ubd_pkg::KIND_BAD;
        end
    end

endmodule

`default_nettype wire

[hdl/ubd_queue.sv]
// Short queue of classified bytes between front and back.
// Depends on ubd_pkg.
`default_nettype none

module ubd_queue
#(
    parameter int DEPTH = ubd_pkg::QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output      logic            can_push,
    input  wire ubd_pkg::item_t  push_item,
    input  wire logic            pop,
    output      logic            not_empty,
    output      ubd_pkg::item_t  head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ubd_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign can_push  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && can_push;
    assign do_pop    = pop && not_empty;
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hdl/ubd_exec.sv]
// Back end: decoder state update and output register.
// Depends on ubd_pkg.
`default_nettype none

module ubd_exec
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    input  wire ubd_pkg::item_t             item,
    output      logic                       item_pop,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic [ubd_pkg::CP_W-1:0]   out_cp,
    output      ubd_pkg::flags_t            out_flags
);

    logic [ubd_pkg::CP_W-1:0]   acc_reg;
    logic [ubd_pkg::CP_W-1:0]   acc_next;
    logic [ubd_pkg::CNT_W-1:0]  left_reg;
    logic [ubd_pkg::CNT_W-1:0]  left_next;
    logic [ubd_pkg::CNT_W-1:0]  seq_reg;
    logic [ubd_pkg::CNT_W-1:0]  seq_next;
    logic                       nov_reg;
    logic                       nov_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [ubd_pkg::CP_W-1:0]   cp_reg;
    logic [ubd_pkg::CP_W-1:0]   cp_next;
    ubd_pkg::flags_t            flags_reg;
    ubd_pkg::flags_t            flags_next;
    logic [5:0]                 low6;
    logic [ubd_pkg::CP_W-1:0]   cont_bits;
    logic [ubd_pkg::CP_W-1:0]   acc_cont;
    logic                       nov_cont;
    logic                       bad_value;

    assign item_pop  = item_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_cp    = cp_reg;
    assign out_flags = flags_reg;
    assign low6      = item.data[5:0];

    // Place the continuation payload by the count still expected
    always_comb
    begin
        unique case (left_reg)
            3'd1:    cont_bits = {25'b0, low6};
            3'd2:    cont_bits = {19'b0, low6, 6'b0};
            3'd3:    cont_bits = {13'b0, low6, 12'b0};
            3'd4:    cont_bits = {7'b0, low6, 18'b0};
            3'd5:    cont_bits = {1'b0, low6, 24'b0};
            3'd6:    cont_bits = {low6[0], 30'b0};
            default: cont_bits = '0;
        endcase
    end

    assign acc_cont  = acc_reg | cont_bits;
    assign nov_cont  = nov_reg ||
                       ((left_reg == seq_reg) && (seq_reg >= 3'd2) && (seq_reg <= 3'd5) &&
                        (low6 >= ubd_pkg::first_cont_limit(seq_reg)));
    assign bad_value = !nov_cont ||
                       ((acc_cont >= ubd_pkg::SURR_LO) && (acc_cont <= ubd_pkg::SURR_HI)) ||
                       (acc_cont == ubd_pkg::NONCHAR_LO) || (acc_cont == ubd_pkg::NONCHAR_HI);

    always_comb
    begin
        acc_next   = acc_reg;
        left_next  = left_reg;
        seq_next   = seq_reg;
        nov_next   = nov_reg;
        valid_next = valid_reg;
        cp_next    = cp_reg;
        flags_next = flags_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (item_pop)
        begin
            valid_next = 1'b1;
            cp_next    = '0;
            flags_next = '0;
            priority if (!item.mode)
            begin
                acc_next            = {23'b0, item.data};
                cp_next             = {23'b0, item.data};
                flags_next.complete = 1'b1;
            end
            else if (left_reg == '0)
            begin
                unique case (item.kind)
                    ubd_pkg::KIND_ASCII:
                    begin
                        acc_next            = {23'b0, item.data};
                        cp_next             = {23'b0, item.data};
                        flags_next.complete = 1'b1;
                    end
                    ubd_pkg::KIND_LEAD:
                    begin
                        acc_next             = item.lead_val;
                        nov_next             = item.nov;
                        seq_next             = item.extra;
                        left_next            = item.extra;
                        cp_next              = item.lead_val;
                        flags_next.need_more = 1'b1;
                    end
                    default:
                    begin
                        // stray continuation or illegal lead: drop
                        acc_next = '0;
                    end
                endcase
            end
            else if (item.kind != ubd_pkg::KIND_CONT)
            begin
                // broken sequence: abandon it and ask for the byte again
                acc_next          = '0;
                left_next         = '0;
                flags_next.resend = 1'b1;
            end
            else
            begin
                nov_next  = nov_cont;
                left_next = left_reg - 1'b1;
                priority if (left_reg != 3'd1)
                begin
                    acc_next             = acc_cont;
                    cp_next              = acc_cont;
                    flags_next.need_more = 1'b1;
                end
                else if (bad_value)
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next            = acc_cont;
                    cp_next             = acc_cont;
                    flags_next.complete = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            left_reg  <= '0;
            seq_reg   <= '0;
            nov_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            seq_reg   <= seq_next;
            nov_reg   <= nov_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg    <= cp_next;
        flags_reg <= flags_next;
    end

endmodule

`default_nettype wire

[hdl/utf8_byte_decoder.sv]
// Top level of the UTF-8 byte decoder: front classifier, queue, back executor.
// Depends on ubd_pkg, ubd_front, ubd_queue and ubd_exec.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   s_      | in        | s_tvalid / s_tready     | s_tdata[7:0]  byte_in
//   m_      | out       | m_tvalid / m_tready     | m_tdata[30:0] code_point,
//           |           |                         | m_tuser complete, need_more, resend
//   cfg_    | in        | cfg_valid / cfg_ready   | cfg_data utf8_mode
//
// One word per cycle sustained while m_tready is high; each accepted byte passes through
// the queue and then the output register before it reaches m_.
// The rate is set by the decoder state update in the back end.
// rst_n clears all control state and sets utf8_mode to 1 (decode).
// The front stalls only when the queue is full; the back stalls on m_tready alone.
`default_nettype none

module utf8_byte_decoder
#(
    parameter int QUEUE_DEPTH = ubd_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input bytes
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    // decoded results
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata,   // [30:0] code_point, [31] zero
    output      logic [2:0]  m_tuser,   // [0] complete, [1] need_more, [2] resend_byte
    // mode register
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_data   // utf8_mode
);

    ubd_pkg::item_t              front_item;
    ubd_pkg::item_t              head_item;
    logic                        q_can_push;
    logic                        q_not_empty;
    logic                        q_pop;
    logic [ubd_pkg::CP_W-1:0]    out_cp;
    ubd_pkg::flags_t             out_flags;

    // Classify each incoming byte and tag it with the current mode
    ubd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .byte_in   (s_tdata),
        .item      (front_item)
    );

    // Accept whenever the queue has room
    assign s_tready = q_can_push;

    ubd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .can_push  (q_can_push),
        .push_item (front_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // Advance the decoder state and hold each result until taken
    ubd_exec u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (head_item),
        .item_pop   (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cp     (out_cp),
        .out_flags  (out_flags)
    );

    assign m_tdata = {1'b0, out_cp};
    assign m_tuser = out_flags;

endmodule

`default_nettype wire
